// ----- rtl/acem_pkg.sv -----
// ----------------------------------------------------------------------------
// acem_pkg: shared types and constants for the error metrics accumulator
// Field widths, register indexes, queue item and result layouts.
// ----------------------------------------------------------------------------
package acem_pkg;

  localparam int DATA_W           = 32;
  localparam int IDX_W            = $clog2(DATA_W);
  localparam int WID_W            = 6;
  localparam int POP_W            = 6;
  localparam int CNT_W            = 21;
  localparam int ABS_W            = 53;
  localparam int SQ_W             = 64;
  localparam int HAM_W            = 26;
  localparam int CFG_ADDR_W       = 8;
  localparam int CFG_DATA_W       = 6;
  localparam int IN_TDATA_W       = 64;
  localparam int OUT_TDATA_W      = 256;

  localparam int MAX_OUT_BITS_DEF = 32;
  localparam int MAX_PATTERNS_DEF = 1048576;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SIGNED_MODE = 8'd0,
    REG_OUTPUT_BITS = 8'd1
  } reg_idx_t;

  typedef struct packed {
    logic             signed_mode;
    logic [WID_W-1:0] output_bits;
  } cfg_t;

  // one classified pattern, front to back
  typedef struct packed {
    logic [DATA_W-1:0] abs_diff;
    logic [DATA_W-1:0] abs_exact;
    logic [POP_W-1:0]  diff_bits;
    logic              mismatch;
    logic              last;
  } item_t;

  // result item; first declared field sits in the highest bits
  typedef struct packed {
    logic [CNT_W-1:0] pattern_count;
    logic [HAM_W-1:0] hamming_sum;
    logic [SQ_W-1:0]  exact_sq_sum;
    logic [SQ_W-1:0]  sq_error_sum;
    logic [ABS_W-1:0] abs_error_sum;
    logic [CNT_W-1:0] mismatch_count;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

// ----- rtl/acem_front.sv -----
// ----------------------------------------------------------------------------
// acem_front: pattern classifier
// Masks both words, applies sign, forms |diff|, |exact| and bit difference count.
// ----------------------------------------------------------------------------
module acem_front #(
  parameter int MAX_OUT_BITS = acem_pkg::MAX_OUT_BITS_DEF
) (
  input  acem_pkg::cfg_t                  cfg,
  input  logic [acem_pkg::DATA_W-1:0]     exact_value,
  input  logic [acem_pkg::DATA_W-1:0]     approx_value,
  input  logic                            last_pattern,
  output acem_pkg::item_t                 item
);
  import acem_pkg::*;

  localparam logic [WID_W-1:0] W_MAX = WID_W'(MAX_OUT_BITS);

  logic [WID_W-1:0]  w_eff;
  logic [IDX_W-1:0]  sign_idx;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] eb;
  logic [DATA_W-1:0] ab;
  logic [DATA_W-1:0] dbits;
  logic              e_neg;
  logic              a_neg;
  logic [DATA_W:0]   ev;
  logic [DATA_W:0]   av;
  logic [DATA_W+1:0] d_pos;
  logic [DATA_W+1:0] d_neg;
  logic [POP_W-1:0]  pop;

  // clamp width to 1..MAX_OUT_BITS
  always_comb begin
    if (cfg.output_bits == '0) begin
      w_eff = WID_W'(1);
    end else if (cfg.output_bits > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = cfg.output_bits;
    end
  end

  assign sign_idx = IDX_W'(w_eff - WID_W'(1));

  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      mask[i] = (WID_W'(i) < w_eff);
    end
  end

  assign eb    = exact_value & mask;
  assign ab    = approx_value & mask;
  assign dbits = eb ^ ab;

  assign e_neg = cfg.signed_mode & eb[sign_idx];
  assign a_neg = cfg.signed_mode & ab[sign_idx];
  // 33-bit two's complement views
  assign ev    = e_neg ? {1'b1, eb | ~mask} : {1'b0, eb};
  assign av    = a_neg ? {1'b1, ab | ~mask} : {1'b0, ab};

  assign d_pos = {ev[DATA_W], ev} - {av[DATA_W], av};
  assign d_neg = {av[DATA_W], av} - {ev[DATA_W], ev};

  // popcount: nibble counts, then eight narrow adds
  always_comb begin
    logic [2:0] nib;
    pop = '0;
    for (int n = 0; n < DATA_W / 4; n++) begin
      nib = 3'(dbits[4*n]) + 3'(dbits[4*n+1]) + 3'(dbits[4*n+2]) + 3'(dbits[4*n+3]);
      pop = pop + POP_W'(nib);
    end
  end

  always_comb begin
    item.abs_diff  = d_pos[DATA_W+1] ? d_neg[DATA_W-1:0] : d_pos[DATA_W-1:0];
    item.abs_exact = ev[DATA_W] ? (~ev[DATA_W-1:0] + DATA_W'(1)) : ev[DATA_W-1:0];
    item.diff_bits = pop;
    item.mismatch  = (dbits != '0);
    item.last      = last_pattern;
  end

endmodule

// ----- rtl/acem_queue.sv -----
// ----------------------------------------------------------------------------
// acem_queue: short item queue between classifier and accumulator
// Register-based FIFO, one push and one pop per cycle; push is held off while full, pop while empty.
// ----------------------------------------------------------------------------
module acem_queue #(
  parameter int DEPTH = acem_pkg::QUEUE_DEPTH_DEF   // 2 or more
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  acem_pkg::item_t din,
  output logic            full,
  input  logic            pop,
  output acem_pkg::item_t dout,
  output logic            empty
);
  import acem_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CQ_W  = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_W-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CQ_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CQ_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- rtl/acem_back.sv -----
// ----------------------------------------------------------------------------
// acem_back: squaring stage and saturating accumulators
// Stage 1 squares |diff| and |exact|; stage 2 accumulates and emits on last.
// ----------------------------------------------------------------------------
module acem_back #(
  parameter int MAX_PATTERNS = acem_pkg::MAX_PATTERNS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  acem_pkg::item_t   q_item,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output acem_pkg::result_t out_res
);
  import acem_pkg::*;

  localparam logic [CNT_W-1:0] PAT_MAX = CNT_W'(MAX_PATTERNS);

  logic              s1_valid_r;
  item_t             s1_item_r;
  logic [SQ_W-1:0]   s1_sq_diff_r;
  logic [SQ_W-1:0]   s1_sq_exact_r;

  logic [CNT_W-1:0]  mismatch_acc_r, mismatch_acc_nxt;
  logic [ABS_W-1:0]  abs_acc_r, abs_acc_nxt;
  logic [SQ_W-1:0]   sq_acc_r, sq_acc_nxt;
  logic [SQ_W-1:0]   exact_sq_acc_r, exact_sq_acc_nxt;
  logic [HAM_W-1:0]  ham_acc_r, ham_acc_nxt;
  logic [CNT_W-1:0]  pat_acc_r, pat_acc_nxt;

  logic              out_valid_r;
  result_t           out_res_r;

  logic              stall, advance, acc_en;
  logic [ABS_W:0]    abs_sum;
  logic [SQ_W:0]     sq_sum;
  logic [SQ_W:0]     exact_sq_sum;
  logic [HAM_W:0]    ham_sum;
  result_t           sums;

  // only a last item needs the output slot
  assign stall   = s1_valid_r & s1_item_r.last & out_valid_r & ~out_ready;
  assign advance = ~stall;
  assign q_pop   = advance & ~q_empty;
  assign acc_en  = s1_valid_r & advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= ~q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item_r     <= q_item;
      s1_sq_diff_r  <= q_item.abs_diff * q_item.abs_diff;
      s1_sq_exact_r <= q_item.abs_exact * q_item.abs_exact;
    end
  end

  assign abs_sum      = {1'b0, abs_acc_r} + (ABS_W+1)'(s1_item_r.abs_diff);
  assign sq_sum       = {1'b0, sq_acc_r} + {1'b0, s1_sq_diff_r};
  assign exact_sq_sum = {1'b0, exact_sq_acc_r} + {1'b0, s1_sq_exact_r};
  assign ham_sum      = {1'b0, ham_acc_r} + (HAM_W+1)'(s1_item_r.diff_bits);

  always_comb begin
    sums.mismatch_count = (s1_item_r.mismatch && mismatch_acc_r != PAT_MAX) ?
                          mismatch_acc_r + CNT_W'(1) : mismatch_acc_r;
    sums.abs_error_sum  = abs_sum[ABS_W] ? '1 : abs_sum[ABS_W-1:0];
    sums.sq_error_sum   = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
    sums.exact_sq_sum   = exact_sq_sum[SQ_W] ? '1 : exact_sq_sum[SQ_W-1:0];
    sums.hamming_sum    = ham_sum[HAM_W] ? '1 : ham_sum[HAM_W-1:0];
    sums.pattern_count  = (pat_acc_r != PAT_MAX) ? pat_acc_r + CNT_W'(1) : pat_acc_r;
  end

  always_comb begin
    mismatch_acc_nxt = mismatch_acc_r;
    abs_acc_nxt      = abs_acc_r;
    sq_acc_nxt       = sq_acc_r;
    exact_sq_acc_nxt = exact_sq_acc_r;
    ham_acc_nxt      = ham_acc_r;
    pat_acc_nxt      = pat_acc_r;
    if (acc_en) begin
      if (s1_item_r.last) begin
        mismatch_acc_nxt = '0;
        abs_acc_nxt      = '0;
        sq_acc_nxt       = '0;
        exact_sq_acc_nxt = '0;
        ham_acc_nxt      = '0;
        pat_acc_nxt      = '0;
      end else begin
        mismatch_acc_nxt = sums.mismatch_count;
        abs_acc_nxt      = sums.abs_error_sum;
        sq_acc_nxt       = sums.sq_error_sum;
        exact_sq_acc_nxt = sums.exact_sq_sum;
        ham_acc_nxt      = sums.hamming_sum;
        pat_acc_nxt      = sums.pattern_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mismatch_acc_r <= '0;
      abs_acc_r      <= '0;
      sq_acc_r       <= '0;
      exact_sq_acc_r <= '0;
      ham_acc_r      <= '0;
      pat_acc_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      mismatch_acc_r <= mismatch_acc_nxt;
      abs_acc_r      <= abs_acc_nxt;
      sq_acc_r       <= sq_acc_nxt;
      exact_sq_acc_r <= exact_sq_acc_nxt;
      ham_acc_r      <= ham_acc_nxt;
      pat_acc_r      <= pat_acc_nxt;
      if (acc_en && s1_item_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en && s1_item_r.last) begin
      out_res_r <= sums;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // a run closes with empty accumulators (at most the next item in)
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_en && s1_item_r.last) |=> (pat_acc_r <= CNT_W'(1)))
    else $error("accumulators not cleared after last item");

  a_mismatch_le_pat: assert property (@(posedge clk) disable iff (!rst_n)
    mismatch_acc_r <= pat_acc_r)
    else $error("mismatch count above pattern count");

  a_ham_implies_mis: assert property (@(posedge clk) disable iff (!rst_n)
    (ham_acc_r != '0) |-> (mismatch_acc_r != '0))
    else $error("differing bits counted without a mismatching pattern");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(acc_en && s1_item_r.last))
    else $error("pending result overwritten");

endmodule

// ----- rtl/approx_circuit_error_metrics_top.sv -----
// ----------------------------------------------------------------------------
// approx_circuit_error_metrics_top: error metrics accumulator for approx circuits
// Streams exact/approx output word pairs and emits ER/MED/MSE/Hamming sums per run.
// ----------------------------------------------------------------------------
// Throughput: one pattern per cycle unless the back end stalls; the queue and one
//   pipeline register per stage keep both sides moving independently.
// Path of the last pattern: queue write, then squaring register, then
//   accumulate into the output register, where the result turns valid.
// A pending result stalls the back end only when the next last pattern arrives.
// Reset (rst_n low, synchronous): accumulators, queue and valid flags clear;
//   signed_mode returns to 0 and output_bits to 32.
// ----------------------------------------------------------------------------
module approx_circuit_error_metrics_top #(
  parameter int MAX_OUT_BITS = acem_pkg::MAX_OUT_BITS_DEF,  // 1..32
  parameter int MAX_PATTERNS = acem_pkg::MAX_PATTERNS_DEF,  // 1..2^20
  parameter int QUEUE_DEPTH  = acem_pkg::QUEUE_DEPTH_DEF    // 2 or more
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pattern input
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] exact_value, [63:32] approx_value
  input  logic [acem_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,    // last_pattern
  // result output
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [20:0] mismatch_count, [73:21] abs_error_sum, [137:74] sq_error_sum,
  // [201:138] exact_sq_sum, [227:202] hamming_sum, [248:228] pattern_count,
  // [255:249] zero
  output logic [acem_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [acem_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [acem_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import acem_pkg::*;

  logic             signed_mode_r;
  logic [WID_W-1:0] output_bits_r;
  cfg_t             cfg;
  item_t            f_item;
  item_t            q_item;
  logic             q_full, q_empty, q_pop, push;
  result_t          res;

  // register file: always ready, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
      output_bits_r <= WID_W'(32);
    end else if (cfg_valid) begin
      if (cfg_addr == REG_SIGNED_MODE) begin
        signed_mode_r <= cfg_data[0];
      end else if (cfg_addr == REG_OUTPUT_BITS) begin
        output_bits_r <= cfg_data[WID_W-1:0];
      end
    end
  end

  assign cfg.signed_mode = signed_mode_r;
  assign cfg.output_bits = output_bits_r;

  // front: classify the incoming pair combinationally, queue registers it
  acem_front #(
    .MAX_OUT_BITS(MAX_OUT_BITS)
  ) u_front (
    .cfg         (cfg),
    .exact_value (in_tdata[DATA_W-1:0]),
    .approx_value(in_tdata[2*DATA_W-1:DATA_W]),
    .last_pattern(in_tlast),
    .item        (f_item)
  );

  assign in_tready = ~q_full;
  assign push      = in_tvalid & in_tready;

  acem_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .din  (f_item),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_item),
    .empty(q_empty)
  );

  // back: square, accumulate, hold the result for the output side
  acem_back #(
    .MAX_PATTERNS(MAX_PATTERNS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_item   (q_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {(OUT_TDATA_W - RES_W)'(0), res};

endmodule

// ----- dv/tb_approx_circuit_error_metrics_top.sv -----
// ----------------------------------------------------------------------------
// tb_approx_circuit_error_metrics_top: self-checking bench for the metrics block
// A directed table (register extremes, width clamping, signed extremes,
// squared-sum saturation, ignored register indexes) runs first, then random
// pattern runs under changing settings. Every result item is compared field by
// field with its hand-written result or an in-bench model of the accumulators.
// Both stream sides idle in random bursts, except in the final stretch.
// ----------------------------------------------------------------------------
module tb_approx_circuit_error_metrics_top;
  import acem_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = 8;       // drain margin past the block's pipeline
  localparam int RANDOM_ITEMS   = 1300;
  localparam int TIMEOUT_CYCLES = 400000;

  // saturation limits of the accumulators
  localparam logic [63:0] CNT_SAT = 64'(MAX_PATTERNS_DEF);
  localparam logic [63:0] ABS_SAT = (64'd1 << ABS_W) - 64'd1;
  localparam logic [63:0] HAM_SAT = (64'd1 << HAM_W) - 64'd1;
  localparam logic [63:0] SQ_SAT  = {64{1'b1}};

  // register indexes the block must ignore
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 8'hFF;

  typedef enum bit {ROW_CFG, ROW_PATTERN} row_kind_t;

  // one row of the directed table
  typedef struct {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] idx;
    logic [CFG_DATA_W-1:0] val;
    logic [DATA_W-1:0]     exact_w;
    logic [DATA_W-1:0]     approx_w;
    logic                  lst;
    bit                    typed;   // hand-written result below is used
    result_t               sums;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [31:0] exact_value, [63:32] approx_value
  logic                   in_tlast;    // last_pattern
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // mismatch_count, abs_error_sum, sq_error_sum,
                                       // exact_sq_sum, hamming_sum, pattern_count
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // hand-written expectation travelling with the driven item
  bit                     hand_typed;
  result_t                hand_sums;

  // bench copy of the registers and accumulators
  logic                   signed_q = 1'b0;
  logic [WID_W-1:0]       width_q  = 6'd32;
  logic [63:0]            count_acc, abs_acc, sqerr_acc, exsq_acc, ham_acc, pat_acc;

  result_t                expected_sums[$];
  row_t                   directed_rows[$];
  int unsigned            fail_count = 0;
  bit                     quiet = 1'b0;    // no idling on either side

  approx_circuit_error_metrics_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Accumulator model
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] clamp_sum(input logic [63:0] a, b, lim);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, lim}) ? lim : s[63:0];
  endfunction

  // Folds one pattern into the accumulators; on a last pattern hands back the
  // sums and clears.
  task automatic accumulate_pattern(input logic [DATA_W-1:0] ew, aw, input logic lst,
                                    output bit emitted, output result_t sums);
    int unsigned w;
    logic [63:0] mask, eb, ab, ad, ae;
    longint      ev, av, d;
    // width 0 acts as 1, anything above the port width as the port width
    w = (width_q == 0) ? 1 : ((width_q > MAX_OUT_BITS_DEF) ? MAX_OUT_BITS_DEF : width_q);
    mask = (64'd1 << w) - 64'd1;
    eb = {32'b0, ew} & mask;
    ab = {32'b0, aw} & mask;
    ev = eb;
    av = ab;
    // two's complement at the configured width
    if (signed_q && eb[w-1]) ev = ev - (longint'(1) << w);
    if (signed_q && ab[w-1]) av = av - (longint'(1) << w);
    d  = ev - av;
    ad = (d < 0) ? -d : d;
    ae = (ev < 0) ? -ev : ev;
    if (eb != ab) count_acc = clamp_sum(count_acc, 64'd1, CNT_SAT);
    abs_acc   = clamp_sum(abs_acc, ad, ABS_SAT);
    sqerr_acc = clamp_sum(sqerr_acc, ad * ad, SQ_SAT);
    exsq_acc  = clamp_sum(exsq_acc, ae * ae, SQ_SAT);
    ham_acc   = clamp_sum(ham_acc, 64'($countones(eb ^ ab)), HAM_SAT);
    pat_acc   = clamp_sum(pat_acc, 64'd1, CNT_SAT);
    emitted = lst;
    sums    = '0;
    if (lst) begin
      sums.mismatch_count = count_acc[CNT_W-1:0];
      sums.abs_error_sum  = abs_acc[ABS_W-1:0];
      sums.sq_error_sum   = sqerr_acc;
      sums.exact_sq_sum   = exsq_acc;
      sums.hamming_sum    = ham_acc[HAM_W-1:0];
      sums.pattern_count  = pat_acc[CNT_W-1:0];
      count_acc = '0;
      abs_acc   = '0;
      sqerr_acc = '0;
      exsq_acc  = '0;
      ham_acc   = '0;
      pat_acc   = '0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t  mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got, want, pred;
    bit      emitted;
    if (rst_n) begin
      // register writes land only while the block is idle
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_SIGNED_MODE: signed_q = cfg_data[0];
          REG_OUTPUT_BITS: width_q  = cfg_data;
          default: ;                        // unused index, ignored
        endcase
      end
      if (in_tvalid && in_tready) begin
        accumulate_pattern(in_tdata[31:0], in_tdata[63:32], in_tlast, emitted, pred);
        if (emitted) expected_sums.push_back(hand_typed ? hand_sums : pred);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[RES_W-1:0];
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("result item with none expected: %h", out_tdata));
        end else begin
          want = expected_sums.pop_front();
          check_field("mismatch_count", got.mismatch_count, want.mismatch_count);
          check_field("abs_error_sum",  got.abs_error_sum,  want.abs_error_sum);
          check_field("sq_error_sum",   got.sq_error_sum,   want.sq_error_sum);
          check_field("exact_sq_sum",   got.exact_sq_sum,   want.exact_sq_sum);
          check_field("hamming_sum",    got.hamming_sum,    want.hamming_sum);
          check_field("pattern_count",  got.pattern_count,  want.pattern_count);
          check_field("tdata pad", 64'(out_tdata[OUT_TDATA_W-1:RES_W]), 64'd0);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready in random stretches, and unless quiet with stalls between
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      out_tready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if (!quiet) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (all input changes at the falling edge)
  // ---------------------------------------------------------------------------
  // Idle: input dropped, all results in, then room for the pipeline to empty
  // of items that produce no result.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_sums.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_addr  = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Leaves in_tvalid high after the handshake; the next call or wait_idle
  // moves it at the following falling edge.
  task automatic send_pattern(input logic [DATA_W-1:0] ew, aw, input logic lst,
                              input bit typed, input result_t sums);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tdata   = {aw, ew};
    in_tlast   = lst;
    hand_typed = typed;
    hand_sums  = sums;
    in_tvalid  = 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------
  function automatic void add_cfg(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, val: val, exact_w: '0, approx_w: '0, lst: 1'b0,
          typed: 1'b0, sums: '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_pat(input logic [DATA_W-1:0] ew, aw, input logic lst);
    row_t r;
    r = '{kind: ROW_PATTERN, idx: '0, val: '0, exact_w: ew, approx_w: aw, lst: lst,
          typed: 1'b0, sums: '0};
    directed_rows.push_back(r);
  endfunction

  // last pattern of a run with its result written out by hand
  function automatic void add_typed(input logic [DATA_W-1:0] ew, aw,
                                    input logic [63:0] mm, ab, sq, esq, ham, pc);
    row_t r;
    r = '{kind: ROW_PATTERN, idx: '0, val: '0, exact_w: ew, approx_w: aw, lst: 1'b1,
          typed: 1'b1, sums: '0};
    r.sums.mismatch_count = mm[CNT_W-1:0];
    r.sums.abs_error_sum  = ab[ABS_W-1:0];
    r.sums.sq_error_sum   = sq;
    r.sums.exact_sq_sum   = esq;
    r.sums.hamming_sum    = ham[HAM_W-1:0];
    r.sums.pattern_count  = pc[CNT_W-1:0];
    directed_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Random word shapes: extremes, small magnitudes, near misses, full words
  // ---------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'($urandom_range(0, 255));
      5: return ~32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_approx(input logic [DATA_W-1:0] ew);
    case ($urandom_range(0, 6))
      0: return ew;                                     // exact match
      1: return ew ^ (32'd1 << $urandom_range(0, 31));  // single bit flip
      2: return ew + 32'($urandom_range(1, 16));
      3: return ew - 32'($urandom_range(1, 16));
      4: return ew ^ $urandom();
      5: return pick_word();
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned             sent;
    int unsigned             phase;
    int unsigned             n_runs;
    int unsigned             run_len;
    bit                      carry;
    logic [CFG_DATA_W-1:0]   bits_val;
    logic [DATA_W-1:0]       ew;
    row_t                    r;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_addr   = '0;
    cfg_data   = '0;
    hand_typed = 1'b0;
    hand_sums  = '0;
    count_acc  = '0;
    abs_acc    = '0;
    sqerr_acc  = '0;
    exsq_acc   = '0;
    ham_acc    = '0;
    pat_acc    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: unsigned, 32 bits
    add_typed(32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0, 0, 1);
    add_typed(32'hFFFF_FFFF, 32'h0000_0000, 1, 64'hFFFF_FFFF,
              64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0001, 32, 1);
    add_typed(32'h0000_0000, 32'hFFFF_FFFF, 1, 64'hFFFF_FFFF,
              64'hFFFF_FFFE_0000_0001, 0, 32, 1);
    // two maximal errors push both squared sums into saturation
    add_pat(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    add_typed(32'hFFFF_FFFF, 32'h0000_0000, 2, 64'h1_FFFF_FFFE, SQ_SAT, SQ_SAT, 64, 2);
    // signed, 32 bits: most negative against most positive
    add_cfg(REG_SIGNED_MODE, 6'h01);
    add_typed(32'h8000_0000, 32'h7FFF_FFFF, 1, 64'hFFFF_FFFF,
              64'hFFFF_FFFE_0000_0001, 64'h4000_0000_0000_0000, 32, 1);
    add_typed(32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 1, 1, 32, 1);
    // width 0 behaves as 1; upper bits ignored
    add_cfg(REG_OUTPUT_BITS, 6'd0);
    add_typed(32'h0000_0001, 32'hFFFF_FFFE, 1, 1, 1, 1, 1, 1);
    add_cfg(REG_OUTPUT_BITS, 6'd1);
    add_typed(32'hFFFF_FFFE, 32'h0000_0000, 0, 0, 0, 0, 0, 1);
    // unsigned again (only bit 0 of the data counts), width 63 clamps to 32
    add_cfg(REG_SIGNED_MODE, 6'h3E);
    add_cfg(REG_OUTPUT_BITS, 6'd63);
    add_typed(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1, 1, 1, 64'hFFFF_FFFE_0000_0001, 1, 1);
    add_cfg(REG_OUTPUT_BITS, 6'd33);
    add_pat(32'h1234_5678, 32'h8765_4321, 1'b0);
    add_pat(32'h0000_0000, 32'h0000_0001, 1'b1);
    // signed 8-bit extremes
    add_cfg(REG_SIGNED_MODE, 6'h01);
    add_cfg(REG_OUTPUT_BITS, 6'd8);
    add_typed(32'h0000_0080, 32'h0000_007F, 1, 255, 64'hFE01, 64'h4000, 8, 1);
    // writes to unused indexes leave signed, 8 bits in place
    add_cfg(REG_UNUSED_LO, 6'h00);
    add_cfg(REG_UNUSED_HI, 6'h3F);
    add_typed(32'h0000_0180, 32'h0000_0080, 0, 0, 0, 64'h4000, 0, 1);
    add_pat(32'h0000_00FF, 32'h0000_0001, 1'b0);
    add_pat(32'h0000_007F, 32'h0000_0080, 1'b0);
    add_pat(32'h1234_5600, 32'h1234_56FF, 1'b1);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.kind == ROW_CFG) begin
        write_reg(r.idx, r.val);
      end else begin
        send_pattern(r.exact_w, r.approx_w, r.lst, r.typed, r.sums);
      end
    end

    // Random phases: new settings, then a few runs. A phase now and then ends
    // without a last pattern, so its sums carry into the next setting.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 8)
        0: bits_val = 6'd1;
        1: bits_val = 6'd32;
        2: bits_val = 6'd0;
        3: bits_val = 6'd63;
        default: begin
          bits_val = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(1, 32));
        end
      endcase
      write_reg(REG_SIGNED_MODE, 6'($urandom_range(0, 63)));
      write_reg(REG_OUTPUT_BITS, bits_val);
      if ($urandom_range(0, 3) == 0)
        write_reg(8'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 6'($urandom_range(0, 63)));
      n_runs = $urandom_range(1, 5);
      carry  = ($urandom_range(0, 7) == 0);
      for (int unsigned run = 0; run < n_runs; run++) begin
        run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        for (int unsigned k = 0; k < run_len; k++) begin
          ew = pick_word();
          send_pattern(ew, pick_approx(ew),
                       (k == run_len - 1) && !(carry && run == n_runs - 1), 1'b0, '0);
          sent++;
          // final stretch runs without idling
          if (sent >= RANDOM_ITEMS * 9 / 10) quiet = 1'b1;
        end
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0 && expected_sums.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/acem_pkg.sv
rtl/acem_front.sv
rtl/acem_queue.sv
rtl/acem_back.sv
rtl/approx_circuit_error_metrics_top.sv
dv/tb_approx_circuit_error_metrics_top.sv
